### hdl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Both macros expect a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### hdl/bvs_pkg.sv
// ----------------------------------------------------------------------------
// Bitplane video scan-out package
// Shared widths, command types, register indexes and the fixed palettes.
// ----------------------------------------------------------------------------
package bvs_pkg;

  // Video store geometry.
  localparam int STORE_BYTES = 16384;
  localparam int STORE_AW    = $clog2(STORE_BYTES);

  // Command queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Field widths.
  localparam int ROW_W   = 8;
  localparam int GROUP_W = 6;
  localparam int DATA_W  = 8;
  localparam int RGB_W   = 24;
  localparam int PAL_W   = 3;
  localparam int CFG_IW  = 2;
  localparam int CFG_DW  = 8;
  localparam int PIX_CW  = 3;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IW-1:0] {
    REG_COLOR_MODE     = 2'd0,
    REG_PALETTE_SELECT = 2'd1,
    REG_SCROLL_OFFSET  = 2'd2
  } cfg_reg_t;

  // Kind of work carried out by the back part.
  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_RENDER = 1'b1
  } cmd_kind_t;

  // One classified command.
  typedef struct packed {
    cmd_kind_t           kind;
    logic [STORE_AW-1:0] addr_a;
    logic [STORE_AW-1:0] addr_b;
    logic [DATA_W-1:0]   data;
    logic                color;
    logic [PAL_W-1:0]    pal;
  } cmd_t;

  // Four-entry color palettes, indexed by {high plane bit, low plane bit}.
  localparam logic [RGB_W-1:0] COLOR_PAL [8][4] = '{
    '{24'h000000, 24'hFF0000, 24'h00FF00, 24'h0000FF},
    '{24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF},
    '{24'h00FF00, 24'hBF00FF, 24'hFF0000, 24'hFFFF00},
    '{24'h000000, 24'h00FFFF, 24'h00FF00, 24'hFFFFFF},
    '{24'h000000, 24'hFFFF00, 24'h00FF00, 24'h0000FF},
    '{24'h000000, 24'hFF0000, 24'h0000FF, 24'hFFFF00},
    '{24'hFF0000, 24'hFFFF00, 24'hFFFFFF, 24'h0000FF},
    '{24'h000000, 24'h000000, 24'h000000, 24'h000000}
  };

  // Two-entry mono palettes.
  localparam logic [RGB_W-1:0] MONO_PAL [8][2] = '{
    '{24'hFFFFFF, 24'h000000},
    '{24'h00007F, 24'h00FF00},
    '{24'hFF0000, 24'h7F0000},
    '{24'hCF00CF, 24'h0000FF},
    '{24'h007F00, 24'hBF00FF},
    '{24'h004B96, 24'hFFFF00},
    '{24'hFF4000, 24'h000000},
    '{24'h7F7F7F, 24'h7F7F7F}
  };

endpackage

### hdl/bvs_if.sv
// ----------------------------------------------------------------------------
// Bitplane video scan-out channel interfaces
// Input item, pixel result and configuration write channels.
// ----------------------------------------------------------------------------

// Input items: store writes and render requests.
interface bvs_item_if;
  import bvs_pkg::*;
  logic               valid;
  logic               ready;
  logic               action;
  logic [STORE_AW-1:0] store_address;
  logic [DATA_W-1:0]  store_data;
  logic [ROW_W-1:0]   screen_row;
  logic [GROUP_W-1:0] group_column;

  modport source (output valid, action, store_address, store_data, screen_row,
                  group_column, input ready);
  modport sink   (input valid, action, store_address, store_data, screen_row,
                  group_column, output ready);
endinterface

// Pixel results.
interface bvs_pixel_if;
  import bvs_pkg::*;
  logic             valid;
  logic             ready;
  logic [RGB_W-1:0] pixel_rgb;
  logic             last_pixel;

  modport source (output valid, pixel_rgb, last_pixel, input ready);
  modport sink   (input valid, pixel_rgb, last_pixel, output ready);
endinterface

// Configuration register writes.
interface bvs_cfg_if;
  import bvs_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/bitplane_video_scanout_core.sv
// ----------------------------------------------------------------------------
// Bitplane video scan-out core
// Input item channel, pixel result channel and configuration write channel.
// An item with action 0 writes one byte of the 16 KiB video store and gives
// no result. An item with action 1 renders one 8-pixel group: eight pixel
// transfers, leftmost first, the eighth marked by last_pixel.
// Accepted items enter a four-entry queue; the back end performs writes and
// fetches both plane bytes of a render together from the store. The first
// pixel of a render is offered after the item passes the queue, the fetch
// stage and the shift stage. A render occupies the pixel channel for eight
// transfers, one pixel per cycle while the receiver is ready; the next fetch
// overlaps the current group. Writes drain at one per cycle unless a render blocks.
// Reset clears the registers (mono, palette 0, scroll 0) and the queue; store
// contents are undefined until written. A stalled receiver holds the current
// pixel; the queue then fills and item ready drops. Configuration is written
// through its own always-ready channel; the user keeps the block idle (unenforced).
// ----------------------------------------------------------------------------
module bitplane_video_scanout_core (
  input  logic        clk,
  input  logic        rst,
  bvs_item_if.sink    item,
  bvs_cfg_if.sink     cfg,
  bvs_pixel_if.source pixel
);
  import bvs_pkg::*;

  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic full;
  logic pop;
  logic empty;

  bvs_front u_front (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cfg    (cfg),
    .q_full (full),
    .q_push (push),
    .q_cmd  (push_cmd)
  );

  bvs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  bvs_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .pixel (pixel)
  );

endmodule

### hdl/bvs_front.sv
// ----------------------------------------------------------------------------
// Bitplane video scan-out front end
// Holds the configuration registers, accepts items and turns each one into a
// store write or a render command with its fetch addresses resolved.
// ----------------------------------------------------------------------------
module bvs_front (
  input  logic          clk,
  input  logic          rst,
  bvs_item_if.sink      item,
  bvs_cfg_if.sink       cfg,
  input  logic          q_full,
  output logic          q_push,
  output bvs_pkg::cmd_t q_cmd
);
  import bvs_pkg::*;

  logic             color_mode;
  logic [PAL_W-1:0] palette_select;
  logic [ROW_W-1:0] scroll_offset;
  logic [ROW_W-1:0] src_row;

  // Configuration registers; unknown indexes are ignored.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode     <= 1'b0;
      palette_select <= '0;
      scroll_offset  <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_COLOR_MODE:     color_mode     <= cfg.data[0];
        REG_PALETTE_SELECT: palette_select <= cfg.data[PAL_W-1:0];
        REG_SCROLL_OFFSET:  scroll_offset  <= cfg.data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // Source row wraps modulo 256 by the natural width of the sum.
  assign src_row = item.screen_row + scroll_offset;

  // An item is taken whenever the queue has room.
  assign item.ready = !q_full;
  assign q_push     = item.valid && !q_full;

  // Classify the item and build the fetch addresses.
  always_comb begin
    q_cmd       = '0;
    q_cmd.data  = item.store_data;
    q_cmd.color = color_mode;
    q_cmd.pal   = palette_select;
    if (item.action) begin
      q_cmd.kind = CMD_RENDER;
      if (color_mode) begin
        // High plane at src + 0x200 * group, low plane 0x100 above it.
        q_cmd.addr_a = {item.group_column[GROUP_W-2:0], 1'b0, src_row};
        q_cmd.addr_b = {item.group_column[GROUP_W-2:0], 1'b1, src_row};
      end else begin
        q_cmd.addr_a = {item.group_column, src_row};
        q_cmd.addr_b = {item.group_column, src_row};
      end
    end else begin
      q_cmd.kind   = CMD_WRITE;
      q_cmd.addr_a = item.store_address;
      q_cmd.addr_b = item.store_address;
    end
  end

endmodule

### hdl/bvs_queue.sv
// ----------------------------------------------------------------------------
// Bitplane video scan-out command queue
// Small in-order queue that lets the front and back parts stall on their own.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bvs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bvs_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output bvs_pkg::cmd_t head,
  output logic          empty
);
  import bvs_pkg::*;

  localparam int CNT_W = QUEUE_AW + 1;

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [CNT_W-1:0]    count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(a_no_overflow, push && full, "queue pushed while full")
  `ASSERT_NEVER(a_no_underflow, pop && empty, "queue popped while empty")

endmodule

### hdl/bvs_back.sv
// ----------------------------------------------------------------------------
// Bitplane video scan-out back end
// Owns the video store, performs writes, fetches plane bytes for renders and
// shifts eight pixels out through the palette, one per transfer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bvs_back (
  input  logic          clk,
  input  logic          rst,
  input  bvs_pkg::cmd_t head,
  input  logic          empty,
  output logic          pop,
  bvs_pixel_if.source   pixel
);
  import bvs_pkg::*;

  logic [DATA_W-1:0] store [STORE_BYTES];

  // Fetch stage: registered read data and render attributes.
  logic              r_valid;
  logic [DATA_W-1:0] r_hi;
  logic [DATA_W-1:0] r_lo;
  logic              r_color;
  logic [PAL_W-1:0]  r_pal;

  // Shift stage feeding the pixel channel.
  logic              s_valid;
  logic [DATA_W-1:0] s_hi;
  logic [DATA_W-1:0] s_lo;
  logic              s_color;
  logic [PAL_W-1:0]  s_pal;
  logic [PIX_CW-1:0] s_cnt;

  logic pix_xfer;
  logic s_done;
  logic r_to_s;
  logic do_write;
  logic do_read;

  // Handshake and stage movement.
  assign pix_xfer = pixel.valid && pixel.ready;
  assign s_done   = pix_xfer && (s_cnt == PIX_CW'(DATA_W - 1));
  assign r_to_s   = r_valid && (!s_valid || s_done);
  assign pop      = !empty && ((head.kind == CMD_WRITE) || !r_valid || r_to_s);
  assign do_write = pop && (head.kind == CMD_WRITE);
  assign do_read  = pop && (head.kind == CMD_RENDER);

  // Video store with one write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (do_write) begin
      store[head.addr_a] <= head.data;
    end
    if (do_read) begin
      r_hi <= store[head.addr_a];
      r_lo <= store[head.addr_b];
    end
  end

  // Fetch stage control and attributes.
  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (do_read) begin
      r_valid <= 1'b1;
    end else if (r_to_s) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      r_color <= head.color;
      r_pal   <= head.pal;
    end
  end

  // Shift stage: load from fetch, otherwise step one pixel per transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      s_cnt   <= '0;
    end else if (r_to_s) begin
      s_valid <= 1'b1;
      s_cnt   <= '0;
    end else if (s_done) begin
      s_valid <= 1'b0;
      s_cnt   <= '0;
    end else if (pix_xfer) begin
      s_cnt <= s_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (r_to_s) begin
      s_hi    <= r_hi;
      s_lo    <= r_lo;
      s_color <= r_color;
      s_pal   <= r_pal;
    end else if (pix_xfer) begin
      s_hi <= s_hi >> 1;
      s_lo <= s_lo >> 1;
    end
  end

  // Palette lookup of the current leftmost bit.
  assign pixel.valid      = s_valid;
  assign pixel.last_pixel = (s_cnt == PIX_CW'(DATA_W - 1));
  assign pixel.pixel_rgb  = s_color ? COLOR_PAL[s_pal][{s_hi[0], s_lo[0]}]
                                    : MONO_PAL[s_pal][s_hi[0]];

  `ASSERT_CLK(a_fetch_holds, r_valid && !r_to_s |=> r_valid, "fetch data dropped")
  `ASSERT_NEVER(a_fetch_no_clobber, do_read && r_valid && !r_to_s,
                "render fetched over pending data")
  `ASSERT_NEVER(a_cnt_idle, !s_valid && (s_cnt != '0), "pixel count moved while idle")

endmodule
